FILE: sv/rxpf_pkg.sv
`default_nettype none

package rxpf_pkg;

    // Default depth of the operator stack.
    localparam int STACK_DEPTH_DEFAULT = 16;

    // Characters with a meaning of their own.
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_OPEN    = 8'h28;
    localparam logic [7:0] CHAR_CLOSE   = 8'h29;
    localparam logic [7:0] CHAR_CAT     = 8'h2E;
    localparam logic [7:0] CHAR_ALT     = 8'h7C;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    // Operator codes held on the stack.
    typedef enum logic [1:0] {
        OP_STAR,
        OP_CAT,
        OP_ALT,
        OP_OPEN
    } op_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_SYM,
        ST_TERM,
        ST_ADJ,
        ST_PAREN,
        ST_BAD,
        ST_OVF
    } status_t;

    // Class of an expression character.
    typedef enum logic [2:0] {
        CLS_LETTER,
        CLS_STAR,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_CAT,
        CLS_ALT,
        CLS_BAD
    } sym_class_t;

    // Source of the character placed in a result.
    typedef enum logic [1:0] {
        SEL_HELD,
        SEL_TOP,
        SEL_OPEN,
        SEL_NEWLINE
    } emit_sel_t;

    // Controller states.
    typedef enum logic {
        CTRL_IDLE,
        CTRL_WORK
    } ctrl_state_t;

    // Input transaction payload.
    typedef struct packed {
        logic       command;
        logic [7:0] symbol;
    } in_item_t;

    // Output transaction payload.
    typedef struct packed {
        logic [7:0] out_symbol;
        status_t    status;
        logic       last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      latch;
        logic      push;
        op_t       push_op;
        logic      pop;
        logic      emit;
        emit_sel_t emit_sel;
        status_t   emit_status;
        logic      emit_last;
        logic      clear;
        logic      set_prev;
        logic      clr_prev;
        logic      set_disc;
        logic      clr_disc;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       is_finish;
        sym_class_t cls;
        logic       discarding;
        logic       prev_blocks;
        logic       empty;
        logic       full;
        logic       open_any;
        op_t        top_op;
        logic       out_free;
    } dp_status_t;

    // Character that an operator code stands for.
    function automatic logic [7:0] op_char(input op_t op);
        logic [7:0] c;
        case (op)
            OP_STAR: c = CHAR_STAR;
            OP_CAT:  c = CHAR_CAT;
            OP_ALT:  c = CHAR_ALT;
            OP_OPEN: c = CHAR_OPEN;
            default: c = CHAR_OPEN;
        endcase
        return c;
    endfunction

    // Sort an expression character into its class.
    function automatic sym_class_t classify(input logic [7:0] c);
        sym_class_t k;
        if ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
            (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z))
        begin
            k = CLS_LETTER;
        end
        else
        begin
            case (c)
                CHAR_STAR:  k = CLS_STAR;
                CHAR_OPEN:  k = CLS_OPEN;
                CHAR_CLOSE: k = CLS_CLOSE;
                CHAR_CAT:   k = CLS_CAT;
                CHAR_ALT:   k = CLS_ALT;
                default:    k = CLS_BAD;
            endcase
        end
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: sv/rxpf_stream_if.sv
`default_nettype none

// Valid/ready channel carrying one payload per transaction.
interface rxpf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/rxpf_dp.sv
`default_nettype none

module rxpf_dp #(
    parameter int STACK_DEPTH = rxpf_pkg::STACK_DEPTH_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rxpf_pkg::in_item_t   in_item,
    input  wire rxpf_pkg::dp_cmd_t    cmd,
    output rxpf_pkg::dp_status_t      status,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output rxpf_pkg::out_item_t       out_item
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    // The top of stack lives in top_reg; entries below it live in the memory.
    rxpf_pkg::op_t      stack_mem [STACK_DEPTH];
    rxpf_pkg::op_t      top_reg;
    rxpf_pkg::op_t      rd_reg;
    rxpf_pkg::in_item_t held_reg;
    rxpf_pkg::out_item_t out_item_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] open_count_reg, open_count_next;
    logic          prev_reg, prev_next;
    logic          disc_reg, disc_next;
    logic          out_valid_reg, out_valid_next;

    logic [CW-1:0] below_top;
    logic [CW-1:0] rd_level;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [7:0]    emit_symbol;

    // Stack depth and count of open parentheses on it.
    always_comb
    begin
        count_next      = count_reg;
        open_count_next = open_count_reg;
        if (cmd.clear)
        begin
            count_next      = '0;
            open_count_next = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
            if (cmd.push_op == rxpf_pkg::OP_OPEN)
            begin
                open_count_next = open_count_reg + CW'(1);
            end
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
            if (top_reg == rxpf_pkg::OP_OPEN)
            begin
                open_count_next = open_count_reg - CW'(1);
            end
        end
    end

    // A push spills the old top into the memory; the read port always
    // prefetches the entry that sits just below the next top.
    assign below_top = count_reg - CW'(1);
    assign rd_level  = count_next - CW'(2);
    assign wr_addr   = below_top[AW-1:0];
    assign rd_addr   = rd_level[AW-1:0];
    assign wr_en     = cmd.push && (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= top_reg;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_reg <= top_reg;
        end
        else
        begin
            rd_reg <= stack_mem[rd_addr];
        end
    end

    // Top of stack register.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            top_reg <= cmd.push_op;
        end
        else if (cmd.pop)
        begin
            top_reg <= rd_reg;
        end
    end

    // Held input transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            held_reg <= in_item;
        end
    end

    // Character placed in the result.
    always_comb
    begin
        case (cmd.emit_sel)
            rxpf_pkg::SEL_HELD:    emit_symbol = held_reg.symbol;
            rxpf_pkg::SEL_TOP:     emit_symbol = rxpf_pkg::op_char(top_reg);
            rxpf_pkg::SEL_OPEN:    emit_symbol = rxpf_pkg::CHAR_OPEN;
            rxpf_pkg::SEL_NEWLINE: emit_symbol = rxpf_pkg::CHAR_NEWLINE;
            default:               emit_symbol = held_reg.symbol;
        endcase
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_item_reg.out_symbol <= emit_symbol;
            out_item_reg.status     <= cmd.emit_status;
            out_item_reg.last       <= cmd.emit_last;
        end
    end

    // Flags and output valid.
    always_comb
    begin
        prev_next = prev_reg;
        if (cmd.set_prev)
        begin
            prev_next = 1'b1;
        end
        else if (cmd.clr_prev || cmd.clear)
        begin
            prev_next = 1'b0;
        end

        disc_next = disc_reg;
        if (cmd.set_disc)
        begin
            disc_next = 1'b1;
        end
        else if (cmd.clr_disc)
        begin
            disc_next = 1'b0;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            open_count_reg <= '0;
            prev_reg       <= 1'b0;
            disc_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            open_count_reg <= open_count_next;
            prev_reg       <= prev_next;
            disc_reg       <= disc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        status.is_finish   = held_reg.command;
        status.cls         = rxpf_pkg::classify(held_reg.symbol);
        status.discarding  = disc_reg;
        status.prev_blocks = prev_reg;
        status.empty       = (count_reg == '0);
        status.full        = (count_reg == DEPTH_C);
        status.open_any    = (open_count_reg != '0);
        status.top_op      = top_reg;
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Open parentheses are a subset of the stack.
    a_open_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        open_count_reg <= count_reg)
        else $error("open paren count exceeds stack count");

    // The stack never grows past its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("stack count exceeds depth");

    // A result is only written into a free output register.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result overwrites a pending transaction");

    // A pop never hits an empty stack.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (count_reg != '0))
        else $error("pop from empty stack");

    // Clearing empties the stack and drops the adjacency flag.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (count_reg == '0 && open_count_reg == '0 && !prev_reg))
        else $error("clear left state behind");

endmodule

`default_nettype wire

FILE: sv/rxpf_ctrl.sv
`default_nettype none

module rxpf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire rxpf_pkg::dp_status_t  status,
    output rxpf_pkg::dp_cmd_t          cmd
);

    rxpf_pkg::ctrl_state_t state_reg, state_next;
    logic                  step_done;
    logic                  want_push;
    rxpf_pkg::op_t         want_op;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rxpf_pkg::CTRL_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rxpf_pkg::CTRL_WORK;
                end
            end
            rxpf_pkg::CTRL_WORK:
            begin
                if (step_done)
                begin
                    state_next = rxpf_pkg::CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = rxpf_pkg::CTRL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rxpf_pkg::CTRL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Outputs: per cycle, one stack step or one result for the held transaction, stalled while out_free is low.
    always_comb
    begin
        cmd             = '0;
        cmd.push_op     = rxpf_pkg::OP_STAR;
        cmd.emit_sel    = rxpf_pkg::SEL_HELD;
        cmd.emit_status = rxpf_pkg::ST_SYM;
        in_ready        = 1'b0;
        step_done       = 1'b0;
        want_push       = 1'b0;
        want_op         = rxpf_pkg::OP_STAR;

        case (state_reg)
            rxpf_pkg::CTRL_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end

            rxpf_pkg::CTRL_WORK:
            begin
                if (status.is_finish)
                begin
                    // Finish: flush, or flag a leftover open paren.
                    if (status.discarding)
                    begin
                        cmd.clear    = 1'b1;
                        cmd.clr_disc = 1'b1;
                        step_done    = 1'b1;
                    end
                    else if (status.out_free)
                    begin
                        if (status.open_any)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_sel    = rxpf_pkg::SEL_OPEN;
                            cmd.emit_status = rxpf_pkg::ST_PAREN;
                            cmd.emit_last   = 1'b1;
                            cmd.clear       = 1'b1;
                            cmd.clr_disc    = 1'b1;
                            step_done       = 1'b1;
                        end
                        else if (!status.empty)
                        begin
                            cmd.pop      = 1'b1;
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = rxpf_pkg::SEL_TOP;
                        end
                        else
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_sel    = rxpf_pkg::SEL_NEWLINE;
                            cmd.emit_status = rxpf_pkg::ST_TERM;
                            cmd.emit_last   = 1'b1;
                            cmd.clear       = 1'b1;
                            cmd.clr_disc    = 1'b1;
                            step_done       = 1'b1;
                        end
                    end
                end
                else if (status.discarding)
                begin
                    step_done = 1'b1;
                end
                else
                begin
                    case (status.cls)
                        rxpf_pkg::CLS_LETTER:
                        begin
                            if (status.out_free)
                            begin
                                cmd.emit  = 1'b1;
                                step_done = 1'b1;
                                if (status.prev_blocks)
                                begin
                                    cmd.emit_status = rxpf_pkg::ST_ADJ;
                                    cmd.emit_last   = 1'b1;
                                    cmd.clear       = 1'b1;
                                    cmd.set_disc    = 1'b1;
                                end
                                else
                                begin
                                    cmd.set_prev = 1'b1;
                                end
                            end
                        end
                        rxpf_pkg::CLS_STAR:
                        begin
                            want_push = 1'b1;
                            want_op   = rxpf_pkg::OP_STAR;
                        end
                        rxpf_pkg::CLS_OPEN:
                        begin
                            cmd.clr_prev = 1'b1;
                            want_push    = 1'b1;
                            want_op      = rxpf_pkg::OP_OPEN;
                        end
                        rxpf_pkg::CLS_CAT:
                        begin
                            cmd.clr_prev = 1'b1;
                            if (!status.empty && (status.top_op == rxpf_pkg::OP_STAR ||
                                                  status.top_op == rxpf_pkg::OP_CAT))
                            begin
                                if (status.out_free)
                                begin
                                    cmd.pop      = 1'b1;
                                    cmd.emit     = 1'b1;
                                    cmd.emit_sel = rxpf_pkg::SEL_TOP;
                                end
                            end
                            else
                            begin
                                want_push = 1'b1;
                                want_op   = rxpf_pkg::OP_CAT;
                            end
                        end
                        rxpf_pkg::CLS_ALT:
                        begin
                            cmd.clr_prev = 1'b1;
                            if (!status.empty && status.top_op != rxpf_pkg::OP_OPEN)
                            begin
                                if (status.out_free)
                                begin
                                    cmd.pop      = 1'b1;
                                    cmd.emit     = 1'b1;
                                    cmd.emit_sel = rxpf_pkg::SEL_TOP;
                                end
                            end
                            else
                            begin
                                want_push = 1'b1;
                                want_op   = rxpf_pkg::OP_ALT;
                            end
                        end
                        rxpf_pkg::CLS_CLOSE:
                        begin
                            cmd.clr_prev = 1'b1;
                            if (!status.open_any)
                            begin
                                if (status.out_free)
                                begin
                                    cmd.emit        = 1'b1;
                                    cmd.emit_status = rxpf_pkg::ST_PAREN;
                                    cmd.emit_last   = 1'b1;
                                    cmd.clear       = 1'b1;
                                    cmd.set_disc    = 1'b1;
                                    step_done       = 1'b1;
                                end
                            end
                            else if (status.top_op != rxpf_pkg::OP_OPEN)
                            begin
                                if (status.out_free)
                                begin
                                    cmd.pop      = 1'b1;
                                    cmd.emit     = 1'b1;
                                    cmd.emit_sel = rxpf_pkg::SEL_TOP;
                                end
                            end
                            else
                            begin
                                // Drop the matching open paren.
                                cmd.pop   = 1'b1;
                                step_done = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (status.out_free)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = rxpf_pkg::ST_BAD;
                                cmd.emit_last   = 1'b1;
                                cmd.clear       = 1'b1;
                                cmd.set_disc    = 1'b1;
                                step_done       = 1'b1;
                            end
                        end
                    endcase

                    // Push the operator, or report overflow on a full stack.
                    if (want_push)
                    begin
                        if (!status.full)
                        begin
                            cmd.push     = 1'b1;
                            cmd.push_op  = want_op;
                            cmd.set_prev = (want_op == rxpf_pkg::OP_STAR);
                            step_done    = 1'b1;
                        end
                        else if (status.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = rxpf_pkg::ST_OVF;
                            cmd.emit_last   = 1'b1;
                            cmd.clear       = 1'b1;
                            cmd.clr_prev    = 1'b0;
                            cmd.set_disc    = 1'b1;
                            step_done       = 1'b1;
                        end
                    end
                end
            end

            default:
            begin
                step_done = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/regex_infix_to_postfix.sv
// Operation: an accepted input transaction is latched into the held register and the
// controller enters its work state, from which it writes each result into the output
// register; each operator popped by ')', '.', '|' or finish gives a result of its own.
// A transaction is taken only in the idle state; output backpressure stalls the work.
// Reset: clears the stack count, the flags, the controller and the output valid; the
// stack memory keeps its contents and is not reset.
`default_nettype none

module regex_infix_to_postfix #(
    parameter int STACK_DEPTH = rxpf_pkg::STACK_DEPTH_DEFAULT
) (
    input wire logic clk,
    input wire logic rst_n,
    rxpf_stream_if.sink   expr,
    rxpf_stream_if.source postfix
);

    rxpf_pkg::dp_cmd_t    cmd;
    rxpf_pkg::dp_status_t status;
    rxpf_pkg::out_item_t  out_item;
    logic                 in_ready;
    logic                 out_valid;

    // Sequencing of each transaction.
    rxpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (expr.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Operator stack, flags and output register.
    rxpf_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (expr.payload),
        .cmd       (cmd),
        .status    (status),
        .out_ready (postfix.ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign expr.ready      = in_ready;
    assign postfix.valid   = out_valid;
    assign postfix.payload = out_item;

endmodule

`default_nettype wire
